[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// bba_pkg
// shared types, constants and address helpers for the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

  localparam int unsigned PoolBytes   = 65536;
  localparam int unsigned MinBytes    = 16;
  localparam int unsigned LevelCount  = 13;
  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned SlotCount   = PoolBytes / MinBytes;
  localparam int unsigned WordBits    = 64;
  localparam int unsigned MapWords    = 133;
  localparam int unsigned MapAw       = 8;
  localparam int unsigned HeldAw      = 12;

  localparam logic [3:0] NotHeld  = 4'hF;
  localparam logic [3:0] TopLevel = 4'(LevelCount - 1);

  typedef enum logic [1:0] {
    ST_GRANT   = 2'd0,
    ST_RELEASE = 2'd1,
    ST_NOSPACE = 2'd2,
    ST_BADREL  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    ACT_ALLOC   = 1'b0,
    ACT_RELEASE = 1'b1
  } action_e;

  typedef struct packed {
    logic [MapAw-1:0] addr;
    logic [5:0]       bit_idx;
  } map_loc_t;

  // first word of each level in the free map memory
  function automatic logic [MapAw-1:0] word_base(input logic [3:0] lvl);
    logic [MapAw-1:0] b;
    case (lvl)
      4'd0:    b = 8'd0;
      4'd1:    b = 8'd64;
      4'd2:    b = 8'd96;
      4'd3:    b = 8'd112;
      4'd4:    b = 8'd120;
      4'd5:    b = 8'd124;
      4'd6:    b = 8'd126;
      4'd7:    b = 8'd127;
      4'd8:    b = 8'd128;
      4'd9:    b = 8'd129;
      4'd10:   b = 8'd130;
      4'd11:   b = 8'd131;
      4'd12:   b = 8'd132;
      default: b = 8'd0;
    endcase
    return b;
  endfunction

  // index of the last word of a level
  function automatic logic [5:0] last_word(input logic [3:0] lvl);
    logic [5:0] w;
    if (lvl <= 4'd6) begin
      w = 6'((7'd64 >> lvl) - 7'd1);
    end else begin
      w = 6'd0;
    end
    return w;
  endfunction

  function automatic map_loc_t map_loc(input logic [3:0] lvl, input logic [15:0] off);
    logic [11:0] blk;
    map_loc_t    r;
    blk       = 12'(off >> (5'(lvl) + 5'd4));
    r.addr    = word_base(lvl) + MapAw'(blk[11:6]);
    r.bit_idx = blk[5:0];
    return r;
  endfunction

  function automatic logic [15:0] block_size(input logic [3:0] lvl);
    return 16'(17'(MinBytes) << lvl);
  endfunction

endpackage

[rtl/bba_ram.sv]
// ----------------------------------------------------------------------------
// bba_ram
// single port ram with registered read data
// ----------------------------------------------------------------------------
module bba_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 133
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/buddy_block_allocator.sv]
// ----------------------------------------------------------------------------
// buddy_block_allocator
// buddy allocator over a 64 KB pool with 16-byte minimum blocks
// ----------------------------------------------------------------------------
// One request is taken at a time and its result leaves through an output
// register, so a new request can be taken while the last result waits.
// After reset the block clears its memories (one held-level slot per cycle,
// the free map alongside the first 133 slots) and is not ready meanwhile.
// The free map lives in a 133 x 64-bit single port ram, one region of words
// per level; the held levels in a 4096 x 4-bit ram. Work per request is
// set by that single map port: an allocation scans the map words from the
// needed level upward, a read and a check per word, and then does a read
// and a write per split level; a release reads the held level, then a read
// and a check per buddy, then reads and writes the freed word. Zero size or
// a request too large for the pool goes straight to its result.
// ----------------------------------------------------------------------------
module buddy_block_allocator
  import bba_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        in_action_i,
  input  logic [16:0] in_request_bytes_i,
  input  logic [15:0] in_release_offset_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  out_status_o,
  output logic [15:0] out_offset_o,
  output logic [3:0]  out_size_level_o
);

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_SRCH_RD  = 16'h0004,
    S_SRCH_CHK = 16'h0008,
    S_SPLIT_RD = 16'h0010,
    S_SPLIT_WR = 16'h0020,
    S_HELD_WR  = 16'h0040,
    S_REL_RD   = 16'h0080,
    S_REL_CHK  = 16'h0100,
    S_BUD_RD   = 16'h0200,
    S_BUD_CHK  = 16'h0400,
    S_FREE_RD  = 16'h0800,
    S_FREE_WR  = 16'h1000,
    S_DONE     = 16'h2000
  } state_e;

  state_e state_q, state_d;

  logic [HeldAw-1:0] clr_q, clr_d;
  logic [3:0]        lvl_q, lvl_d;     // working level
  logic [3:0]        need_q, need_d;   // level asked for
  logic [15:0]       off_q, off_d;     // working block offset
  logic [5:0]        wi_q, wi_d;       // word within level during scan
  logic [1:0]        res_st_q, res_st_d;
  logic [15:0]       res_off_q, res_off_d;
  logic [3:0]        res_lvl_q, res_lvl_d;

  logic              ov_q, ov_d;
  logic [1:0]        ost_q, ost_d;
  logic [15:0]       ooff_q, ooff_d;
  logic [3:0]        olvl_q, olvl_d;

  // memory ports
  logic                map_we;
  logic [MapAw-1:0]    map_addr;
  logic [WordBits-1:0] map_wdata, map_rdata;
  logic                held_we;
  logic [HeldAw-1:0]   held_addr;
  logic [3:0]          held_wdata, held_rdata;

  bba_ram #(.Width(WordBits), .Depth(MapWords)) u_map (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .addr_i  (map_addr),
    .wdata_i (map_wdata),
    .rdata_o (map_rdata)
  );

  bba_ram #(.Width(4), .Depth(SlotCount)) u_held (
    .clk_i   (clk_i),
    .we_i    (held_we),
    .addr_i  (held_addr),
    .wdata_i (held_wdata),
    .rdata_o (held_rdata)
  );

  // request decode at the input
  logic [17:0] need_bytes;
  logic [3:0]  need_lvl;
  logic        need_fits;
  logic [15:0] rel_off;

  always_comb begin
    need_bytes = {1'b0, in_request_bytes_i} + 18'(HeaderBytes);
    need_lvl   = TopLevel;
    for (int l = int'(LevelCount) - 1; l >= 0; l--) begin
      if ((18'(MinBytes) << l) >= need_bytes) begin
        need_lvl = 4'(l);
      end
    end
    need_fits = need_bytes <= 18'(PoolBytes);
    rel_off   = in_release_offset_i - 16'(HeaderBytes);
  end

  // lowest set bit of the map word just read
  logic [5:0] ffs;
  always_comb begin
    ffs = '0;
    for (int i = int'(WordBits) - 1; i >= 0; i--) begin
      if (map_rdata[i]) begin
        ffs = 6'(i);
      end
    end
  end

  map_loc_t own_loc, bud_loc;
  assign own_loc = map_loc(lvl_q, off_q);
  assign bud_loc = map_loc(lvl_q, off_q ^ block_size(lvl_q));

  logic out_free;
  assign out_free   = !ov_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    lvl_d     = lvl_q;
    need_d    = need_q;
    off_d     = off_q;
    wi_d      = wi_q;
    res_st_d  = res_st_q;
    res_off_d = res_off_q;
    res_lvl_d = res_lvl_q;
    ov_d      = ov_q && !out_ready_i;
    ost_d     = ost_q;
    ooff_d    = ooff_q;
    olvl_d    = olvl_q;

    map_we     = 1'b0;
    map_addr   = own_loc.addr;
    map_wdata  = map_rdata | (WordBits'(1) << own_loc.bit_idx);
    held_we    = 1'b0;
    held_addr  = off_q[15:4];
    held_wdata = NotHeld;

    case (state_q)
      S_CLEAR: begin
        // clear both memories, leave only the whole pool free
        held_we    = 1'b1;
        held_addr  = clr_q;
        held_wdata = NotHeld;
        map_addr   = clr_q[MapAw-1:0];
        map_we     = clr_q < HeldAw'(MapWords);
        map_wdata  = (clr_q == HeldAw'(MapWords - 1)) ? WordBits'(1) : '0;
        clr_d      = clr_q + 1'b1;
        if (clr_q == HeldAw'(SlotCount - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          res_off_d = '0;
          res_lvl_d = '0;
          if (in_action_i == ACT_ALLOC) begin
            if (in_request_bytes_i == '0 || !need_fits) begin
              res_st_d = ST_NOSPACE;
              state_d  = S_DONE;
            end else begin
              need_d  = need_lvl;
              lvl_d   = need_lvl;
              wi_d    = '0;
              state_d = S_SRCH_RD;
            end
          end else begin
            if (in_release_offset_i < 16'(HeaderBytes) || rel_off[3:0] != 4'd0) begin
              res_st_d = ST_BADREL;
              state_d  = S_DONE;
            end else begin
              off_d   = rel_off;
              state_d = S_REL_RD;
            end
          end
        end
      end
      S_SRCH_RD: begin
        map_addr = word_base(lvl_q) + MapAw'(wi_q);
        state_d  = S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        map_addr = word_base(lvl_q) + MapAw'(wi_q);
        if (map_rdata != '0) begin
          // take the block and mark it used in the same word
          map_we    = 1'b1;
          map_wdata = map_rdata & ~(WordBits'(1) << ffs);
          off_d     = 16'(28'({wi_q, ffs}) << (5'(lvl_q) + 5'd4));
          if (lvl_q == need_q) begin
            state_d = S_HELD_WR;
          end else begin
            lvl_d   = lvl_q - 1'b1;
            state_d = S_SPLIT_RD;
          end
        end else if (wi_q == last_word(lvl_q)) begin
          if (lvl_q == TopLevel) begin
            res_st_d  = ST_NOSPACE;
            res_off_d = '0;
            res_lvl_d = '0;
            state_d   = S_DONE;
          end else begin
            lvl_d   = lvl_q + 1'b1;
            wi_d    = '0;
            state_d = S_SRCH_RD;
          end
        end else begin
          wi_d    = wi_q + 1'b1;
          state_d = S_SRCH_RD;
        end
      end
      S_SPLIT_RD: begin
        map_addr = bud_loc.addr;
        state_d  = S_SPLIT_WR;
      end
      S_SPLIT_WR: begin
        // right half of the split becomes free
        map_addr  = bud_loc.addr;
        map_we    = 1'b1;
        map_wdata = map_rdata | (WordBits'(1) << bud_loc.bit_idx);
        if (lvl_q == need_q) begin
          state_d = S_HELD_WR;
        end else begin
          lvl_d   = lvl_q - 1'b1;
          state_d = S_SPLIT_RD;
        end
      end
      S_HELD_WR: begin
        held_we    = 1'b1;
        held_wdata = need_q;
        res_st_d   = ST_GRANT;
        res_off_d  = off_q + 16'(HeaderBytes);
        res_lvl_d  = need_q;
        state_d    = S_DONE;
      end
      S_REL_RD: begin
        state_d = S_REL_CHK;
      end
      S_REL_CHK: begin
        if (held_rdata >= 4'(LevelCount)) begin
          res_st_d = ST_BADREL;
          state_d  = S_DONE;
        end else begin
          held_we = 1'b1;
          lvl_d   = held_rdata;
          state_d = (held_rdata == TopLevel) ? S_FREE_RD : S_BUD_RD;
        end
      end
      S_BUD_RD: begin
        map_addr = bud_loc.addr;
        state_d  = S_BUD_CHK;
      end
      S_BUD_CHK: begin
        map_addr = bud_loc.addr;
        if (map_rdata[bud_loc.bit_idx]) begin
          // buddy free: absorb it and go one level up
          map_we    = 1'b1;
          map_wdata = map_rdata & ~(WordBits'(1) << bud_loc.bit_idx);
          off_d     = off_q & ~block_size(lvl_q);
          lvl_d     = lvl_q + 1'b1;
          state_d   = (lvl_q + 1'b1 == TopLevel) ? S_FREE_RD : S_BUD_RD;
        end else begin
          state_d = S_FREE_RD;
        end
      end
      S_FREE_RD: begin
        state_d = S_FREE_WR;
      end
      S_FREE_WR: begin
        map_we    = 1'b1;
        res_st_d  = ST_RELEASE;
        res_off_d = off_q;
        res_lvl_d = lvl_q;
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          ov_d    = 1'b1;
          ost_d   = res_st_q;
          ooff_d  = res_off_q;
          olvl_d  = res_lvl_q;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q   <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      clr_q   <= clr_d;
      ov_q    <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lvl_q     <= lvl_d;
    need_q    <= need_d;
    off_q     <= off_d;
    wi_q      <= wi_d;
    res_st_q  <= res_st_d;
    res_off_q <= res_off_d;
    res_lvl_q <= res_lvl_d;
    ost_q     <= ost_d;
    ooff_q    <= ooff_d;
    olvl_q    <= olvl_d;
  end

  assign out_valid_o      = ov_q;
  assign out_status_o     = ost_q;
  assign out_offset_o     = ooff_q;
  assign out_size_level_o = olvl_q;

  // ready drops after every accepted request
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("ready right after a transfer");

  // a granted payload sits one header past a block boundary
  a_grant_align: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_status_o == ST_GRANT |->
      out_offset_o[3:0] == 4'd8 && out_size_level_o <= TopLevel)
    else $error("granted offset misaligned");

  // failed requests carry zero fields
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_status_o == ST_NOSPACE || out_status_o == ST_BADREL) |->
      out_offset_o == '0 && out_size_level_o == '0)
    else $error("failure result not zeroed");

endmodule

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// buddy allocator testbench: a table of directed requests, then random
// allocate/release traffic checked against a behavioral model of the pool
// ----------------------------------------------------------------------------
module tb_top;
  import bba_pkg::*;

  localparam int unsigned MapDepth  = 2 * SlotCount - 1;
  localparam int unsigned RandItems = 1900;
  localparam int unsigned WdLimit   = 20000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] offset;
    logic [3:0]  size_level;
  } grant_t;

  typedef struct {
    action_e     act;
    logic [16:0] bytes;
    logic [15:0] rel;
    bit          typed;
    grant_t      want;
  } req_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        in_action_i = 1'b0;
  logic [16:0] in_request_bytes_i = '0;
  logic [15:0] in_release_offset_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [1:0]  out_status_o;
  logic [15:0] out_offset_o;
  logic [3:0]  out_size_level_o;

  always #1 clk_i = ~clk_i;

  buddy_block_allocator dut (.*);

  // model state: free bit per block per level, level held at each slot
  bit          pool_free [MapDepth];
  logic [3:0]  slot_level [SlotCount];
  logic [15:0] live_offsets [$];
  grant_t      pending_grants [$];

  int unsigned errors = 0;
  int unsigned n_sent = 0;
  int unsigned n_seen = 0;
  int unsigned n_grant = 0;
  int unsigned n_rel = 0;
  int unsigned n_nospace = 0;
  int unsigned n_badrel = 0;
  int unsigned idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          stim_done = 1'b0;

  function automatic int unsigned map_idx(int unsigned lvl, int unsigned off);
    int unsigned base;
    base = 0;
    for (int k = 0; k < lvl; k++) base += SlotCount >> k;
    return base + off / (MinBytes << lvl);
  endfunction

  function automatic void pool_reset();
    foreach (pool_free[i]) pool_free[i] = 1'b0;
    foreach (slot_level[i]) slot_level[i] = NotHeld;
    pool_free[map_idx(LevelCount - 1, 0)] = 1'b1;
  endfunction

  // apply one request to the model pool and return the response it earns
  function automatic grant_t pool_apply(action_e act, logic [16:0] bytes,
                                        logic [15:0] rel);
    grant_t      g;
    int unsigned need, lvl, found, off, size;
    bit          hit;
    g = '0;
    hit = 1'b0;
    off = 0;
    if (act == ACT_ALLOC) begin
      g.status = ST_NOSPACE;
      if (bytes == 0) return g;
      need = bytes + HeaderBytes;
      lvl = 0;
      while (lvl < LevelCount && (MinBytes << lvl) < need) lvl++;
      if (lvl >= LevelCount) return g;
      for (found = lvl; found < LevelCount; found++) begin
        size = MinBytes << found;
        for (off = 0; off < PoolBytes; off += size)
          if (pool_free[map_idx(found, off)]) begin
            hit = 1'b1;
            break;
          end
        if (hit) break;
      end
      if (!hit) return g;
      pool_free[map_idx(found, off)] = 1'b0;
      while (found > lvl) begin
        found--;
        pool_free[map_idx(found, off + (MinBytes << found))] = 1'b1;
      end
      slot_level[off / MinBytes] = 4'(lvl);
      g.status = ST_GRANT;
      g.offset = 16'(off + HeaderBytes);
      g.size_level = 4'(lvl);
    end else begin
      g.status = ST_BADREL;
      if (rel < HeaderBytes) return g;
      off = rel - HeaderBytes;
      if (off % MinBytes != 0) return g;
      if (slot_level[off / MinBytes] >= LevelCount) return g;
      lvl = slot_level[off / MinBytes];
      slot_level[off / MinBytes] = NotHeld;
      while (lvl + 1 < LevelCount) begin
        size = off ^ (MinBytes << lvl);
        if (!pool_free[map_idx(lvl, size)]) break;
        pool_free[map_idx(lvl, size)] = 1'b0;
        if (size < off) off = size;
        lvl++;
      end
      pool_free[map_idx(lvl, off)] = 1'b1;
      g.status = ST_RELEASE;
      g.offset = 16'(off);
      g.size_level = 4'(lvl);
    end
    return g;
  endfunction

  task automatic gap(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // one request transfer; the model is updated at acceptance
  // valid stays high into the next call when no idle cycles are drawn
  task automatic send_req(action_e act, logic [16:0] bytes, logic [15:0] rel,
                          bit typed, grant_t want, bit may_idle);
    grant_t      g;
    int unsigned w;
    w = may_idle ? $urandom_range(0, 13) : 0;
    if (w != 0) begin
      in_valid_i <= 1'b0;
      gap(w);
    end
    in_valid_i <= 1'b1;
    in_action_i <= act;
    in_request_bytes_i <= bytes;
    in_release_offset_i <= rel;
    do @(posedge clk_i); while (!in_ready_o);
    g = pool_apply(act, bytes, rel);
    if (typed && g != want) begin
      $display("%0t table row disagrees with model: expected %h model %h",
               $time, want, g);
      errors++;
    end
    if (g.status == ST_GRANT) live_offsets.push_back(g.offset);
    pending_grants.push_back(g);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk_i);
  endtask

  // random release of a live block, wrong offset now and then
  task automatic rand_release();
    int unsigned k;
    logic [15:0] r;
    if (live_offsets.size() != 0 && $urandom_range(0, 9) != 0) begin
      k = $urandom_range(0, live_offsets.size() - 1);
      r = live_offsets[k];
      live_offsets.delete(k);
    end else begin
      r = 16'($urandom);
    end
    send_req(ACT_RELEASE, '0, r, 1'b0, '0, 1'b1);
  endtask

  function automatic logic [16:0] rand_bytes();
    case ($urandom_range(0, 9))
      0:       return 17'($urandom_range(0, 65536));
      1:       return 17'($urandom);
      2:       return 17'($urandom_range(0, 8));
      default: return 17'($urandom_range(1, 1000));
    endcase
  endfunction

  // receiver: random stalls, plus one long hold-off
  initial begin
    int unsigned w;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        long_hold = 1'b0;
      end
      w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (w != 0) begin
        out_ready_i <= 1'b0;
        repeat (w) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // response checker
  always @(posedge clk_i) begin
    grant_t got, exp_g;
    if (out_valid_o && out_ready_i) begin
      got = {out_status_o, out_offset_o, out_size_level_o};
      n_seen++;
      if (pending_grants.size() == 0) begin
        $display("%0t unexpected response: actual %h", $time, got);
        errors++;
      end else begin
        exp_g = pending_grants.pop_front();
        case (exp_g.status)
          ST_GRANT:   n_grant++;
          ST_RELEASE: n_rel++;
          ST_NOSPACE: n_nospace++;
          default:    n_badrel++;
        endcase
        if (got.status != exp_g.status)
          $display("%0t status mismatch: expected %0d actual %0d",
                   $time, exp_g.status, got.status);
        if (got.offset != exp_g.offset)
          $display("%0t offset mismatch: expected %h actual %h",
                   $time, exp_g.offset, got.offset);
        if (got.size_level != exp_g.size_level)
          $display("%0t level mismatch: expected %0d actual %0d",
                   $time, exp_g.size_level, got.size_level);
        if (got != exp_g) errors++;
      end
    end
  end

  // watchdog on cycles with no transfer; covers the clearing pass too
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || stim_done)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WdLimit) begin
      $display("%0t watchdog expired, %0d responses outstanding",
               $time, pending_grants.size());
      $display("tb_top failed");
      $finish;
    end
  end

  initial begin
    req_row_t rows [$];
    int unsigned guard;
    pool_reset();
    // directed table: typed expectations only where obvious
    rows.push_back('{ACT_ALLOC, 17'd0, 16'd0, 1'b1, '{ST_NOSPACE, 16'd0, 4'd0}});
    rows.push_back('{ACT_ALLOC, 17'h1FFFF, 16'd0, 1'b1, '{ST_NOSPACE, 16'd0, 4'd0}});
    rows.push_back('{ACT_ALLOC, 17'd65536, 16'd0, 1'b1, '{ST_NOSPACE, 16'd0, 4'd0}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd0, 1'b1, '{ST_BADREL, 16'd0, 4'd0}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd23, 1'b1, '{ST_BADREL, 16'd0, 4'd0}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd24, 1'b1, '{ST_BADREL, 16'd0, 4'd0}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'hFFFF, 1'b1, '{ST_BADREL, 16'd0, 4'd0}});
    // whole pool, release merges nothing
    rows.push_back('{ACT_ALLOC, 17'd65512, 16'd0, 1'b1, '{ST_GRANT, 16'd24, 4'd12}});
    rows.push_back('{ACT_ALLOC, 17'd1, 16'd0, 1'b1, '{ST_NOSPACE, 16'd0, 4'd0}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd24, 1'b1, '{ST_RELEASE, 16'd0, 4'd12}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd24, 1'b1, '{ST_BADREL, 16'd0, 4'd0}});
    // smallest grant (level 1): full split, then bad and good releases
    rows.push_back('{ACT_ALLOC, 17'd1, 16'd0, 1'b1, '{ST_GRANT, 16'd24, 4'd1}});
    rows.push_back('{ACT_ALLOC, 17'd8, 16'd0, 1'b0, '0});
    rows.push_back('{ACT_ALLOC, 17'd9, 16'd0, 1'b0, '0});
    rows.push_back('{ACT_ALLOC, 17'd32744, 16'd0, 1'b0, '0});
    rows.push_back('{ACT_ALLOC, 17'd32745, 16'd0, 1'b0, '0});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd40, 1'b0, '0});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd25, 1'b1, '{ST_BADREL, 16'd0, 4'd0}});
    rows.push_back('{ACT_RELEASE, 17'd0, 16'd24, 1'b0, '0});
    rows.push_back('{ACT_ALLOC, 17'h10000, 16'd0, 1'b1, '{ST_NOSPACE, 16'd0, 4'd0}});

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (rows[i])
      send_req(rows[i].act, rows[i].bytes, rows[i].rel, rows[i].typed,
               rows[i].want, 1'b1);
    // sender pauses until every response is back
    drain();
    // fill-up phase under a long receiver hold-off
    long_hold = 1'b1;
    repeat (40) send_req(ACT_ALLOC, 17'($urandom_range(1, 200)), '0, 1'b0, '0, 1'b0);
    drain();
    // random traffic: bursts of allocations and releases to fragment the pool
    for (int i = 0; i < RandItems; i++) begin
      if ($urandom_range(0, 1) == 0 || live_offsets.size() == 0)
        send_req(ACT_ALLOC, rand_bytes(), 16'($urandom), 1'b0, '0,
                 $urandom_range(0, 2) == 0);
      else
        rand_release();
    end
    // release what is left so the pool merges back to one block
    while (live_offsets.size() != 0)
      send_req(ACT_RELEASE, '0, live_offsets.pop_front(), 1'b0, '0, 1'b0);
    in_valid_i <= 1'b0;
    guard = 0;
    while (pending_grants.size() != 0 && guard < 100000) begin
      @(posedge clk_i);
      guard++;
    end
    stim_done = 1'b1;
    repeat (300) @(posedge clk_i);
    $display("%0d requests, %0d responses: %0d grants, %0d releases,",
             n_sent, n_seen, n_grant, n_rel);
    $display("%0d no-space and %0d bad-release responses", n_nospace, n_badrel);
    if (errors == 0 && pending_grants.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
